[src/cmg_pkg.sv]
// Shared types and constants for the month calendar grid block.
// No dependencies; used by every module in src.
package cmg_pkg;

   localparam int ACC_W = 12;

   localparam logic [11:0] YEAR_MIN    = 12'd1601;
   localparam logic [11:0] YEAR_MAX    = 12'd3000;
   localparam logic [3:0]  MONTH_JAN   = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_APR   = 4'd4;
   localparam logic [3:0]  MONTH_JUN   = 4'd6;
   localparam logic [3:0]  MONTH_SEP   = 4'd9;
   localparam logic [3:0]  MONTH_NOV   = 4'd11;
   localparam logic [3:0]  MONTH_DEC   = 4'd12;

   localparam logic [11:0] DIV_CENTURY = 12'd100;
   localparam logic [11:0] DIV_WEEK    = 12'd7;
   localparam logic [8:0]  DAY_BIAS    = 9'd63;   // multiple of 7, keeps the sum positive
   localparam logic [6:0]  YY_WRAP     = 7'd99;

   localparam logic [4:0]  LEN_28      = 5'd28;
   localparam logic [4:0]  LEN_29      = 5'd29;
   localparam logic [4:0]  LEN_30      = 5'd30;
   localparam logic [4:0]  LEN_31      = 5'd31;

   localparam logic [5:0]  SPAN_4WK    = 6'd28;
   localparam logic [5:0]  SPAN_5WK    = 6'd35;
   localparam logic [5:0]  LASTK_4WK   = 6'd27;
   localparam logic [5:0]  LASTK_5WK   = 6'd34;
   localparam logic [5:0]  LASTK_6WK   = 6'd41;
   localparam logic [2:0]  COL_SUN     = 3'd6;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
   } req_type;

   typedef struct packed {
      logic [4:0] day_number;
      logic [2:0] weekday_column;
      logic [2:0] first_weekday;
      logic [4:0] month_length;
      logic       request_error;
      logic       last_cell;
   } rsp_type;

   typedef struct packed {
      logic       go;
      logic       err;
      logic [2:0] fw;
      logic [4:0] len;
   } grid_cmd_type;

   // floor((13*(m-2)-1)/5) with Jan/Feb taken as months 13/14
   function automatic logic [4:0] month_term(input logic [3:0] month);
      logic [4:0] t;
      case (month)
         4'd1:    t = 5'd28;
         4'd2:    t = 5'd31;
         4'd3:    t = 5'd2;
         4'd4:    t = 5'd5;
         4'd5:    t = 5'd7;
         4'd6:    t = 5'd10;
         4'd7:    t = 5'd12;
         4'd8:    t = 5'd15;
         4'd9:    t = 5'd18;
         4'd10:   t = 5'd20;
         4'd11:   t = 5'd23;
         4'd12:   t = 5'd25;
         default: t = 5'd0;
      endcase
      return t;
   endfunction

endpackage

[src/cmg_sub_step.sv]
// Shared compare-and-subtract step used for the century split and modulo 7.
// Depends on cmg_pkg.
module cmg_sub_step (
   input  logic [cmg_pkg::ACC_W-1:0] acc,
   input  logic [cmg_pkg::ACC_W-1:0] divisor,
   output logic                      ge,
   output logic [cmg_pkg::ACC_W-1:0] diff
);

   assign ge   = (acc >= divisor);
   assign diff = acc - divisor;

endmodule

[src/cmg_grid.sv]
// Cell emitter: walks the month grid one beat per cycle into the output register while the receiver does not stall.
// Depends on cmg_pkg.
module cmg_grid (
   input  logic                  clock,
   input  logic                  reset,
   input  cmg_pkg::grid_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cmg_pkg::rsp_type      rsp_data
);

   logic             busy_ff, busy_in;
   logic             err_ff, err_in;
   logic [2:0]       fw_ff, fw_in;
   logic [4:0]       len_ff, len_in;
   logic [5:0]       k_ff, k_in;
   logic [2:0]       col_ff, col_in;
   logic [5:0]       lastk_ff, lastk_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cmg_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic [5:0]       span;
   logic [5:0]       end_k;
   logic [5:0]       rel_k;
   logic             in_month;
   logic             is_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign span     = {3'd0, cmd.fw} + {1'b0, cmd.len};
   assign end_k    = {3'd0, fw_ff} + {1'b0, len_ff};
   assign rel_k    = k_ff - {3'd0, fw_ff};
   assign in_month = (k_ff >= {3'd0, fw_ff}) && (k_ff < end_k);
   assign is_last  = err_ff || (k_ff == lastk_ff);

   always_comb begin
      busy_in      = busy_ff;
      err_in       = err_ff;
      fw_in        = fw_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      col_in       = col_ff;
      lastk_in     = lastk_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.go) begin
         busy_in  = 1'b1;
         err_in   = cmd.err;
         fw_in    = cmd.fw;
         len_in   = cmd.len;
         k_in     = 6'd0;
         col_in   = 3'd0;
         if (span <= cmg_pkg::SPAN_4WK) begin
            lastk_in = cmg_pkg::LASTK_4WK;
         end else if (span <= cmg_pkg::SPAN_5WK) begin
            lastk_in = cmg_pkg::LASTK_5WK;
         end else begin
            lastk_in = cmg_pkg::LASTK_6WK;
         end
      end else if (busy_ff && out_free) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            rsp_data_in = '0;
            rsp_data_in.request_error = 1'b1;
         end else begin
            rsp_data_in.day_number     = in_month ? 5'(rel_k + 6'd1) : 5'd0;
            rsp_data_in.weekday_column = col_ff;
            rsp_data_in.first_weekday  = fw_ff;
            rsp_data_in.month_length   = len_ff;
            rsp_data_in.request_error  = 1'b0;
         end
         rsp_data_in.last_cell = is_last;
         k_in   = k_ff + 6'd1;
         col_in = (col_ff == cmg_pkg::COL_SUN) ? 3'd0 : col_ff + 3'd1;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff      <= err_in;
      fw_ff       <= fw_in;
      len_ff      <= len_in;
      k_ff        <= k_in;
      col_ff      <= col_in;
      lastk_ff    <= lastk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/calendar_month_grid.sv]
// Top level of the month calendar grid block: request sequencer and unit wiring.
// Depends on cmg_pkg, cmg_sub_step and cmg_grid.
//
// Use: a request beat on req_ (year, month) produces the Monday-first grid of
// that month on rsp_, one cell per beat: leading blanks, days 1..N, trailing
// blanks to the end of the week. The final cell carries last_cell. A year
// outside 1601..3000 or a month outside 1..12 gives one error beat.
// Timing: one compare-subtract unit first splits the year by 100 (up to 30
// steps, one per cycle), then reduces the weekday sum modulo 7 (up to 27
// steps). The grid then drives 28, 35 or 42 beats, one per cycle when the
// receiver does not stall. req_stall stays high until the last beat of the
// current request has been loaded into the output register. When rsp_stall
// is high while a beat is valid, the output register holds that beat and the
// emitter waits. Reset is synchronous; it drops all pending beats and returns
// the block to idle.
module calendar_month_grid (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cmg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cmg_pkg::rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_MOD  = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [cmg_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [4:0]                cen_ff, cen_in;
   logic [3:0]                month_ff, month_in;
   logic [1:0]                ylo_ff, ylo_in;
   logic [4:0]                len_ff, len_in;

   logic [cmg_pkg::ACC_W-1:0] divisor;
   logic                      ge;
   logic [cmg_pkg::ACC_W-1:0] diff;
   logic                      grid_busy;
   cmg_pkg::grid_cmd_type     cmd;
   logic                      accept;
   logic                      bad_req;

   logic [6:0]                yy;
   logic                      early;
   logic                      yy_zero;
   logic [6:0]                yy_adj;
   logic [4:0]                cen_adj;
   logic [8:0]                dsum;
   logic                      leap;
   logic [2:0]                rem;

   assign req_stall = (state_ff != ST_IDLE) || grid_busy;
   assign accept    = req_valid && !req_stall;
   assign bad_req   = (req_data.year < cmg_pkg::YEAR_MIN) || (req_data.year > cmg_pkg::YEAR_MAX)
                      || (req_data.month < cmg_pkg::MONTH_JAN)
                      || (req_data.month > cmg_pkg::MONTH_DEC);

   assign divisor = (state_ff == ST_MOD) ? cmg_pkg::DIV_WEEK : cmg_pkg::DIV_CENTURY;

   cmg_sub_step u_sub (
      .acc     (acc_ff),
      .divisor (divisor),
      .ge      (ge),
      .diff    (diff)
   );

   assign yy      = acc_ff[6:0];
   assign early   = (month_ff <= cmg_pkg::MONTH_FEB);
   assign yy_zero = (yy == 7'd0);
   assign yy_adj  = !early ? yy : (yy_zero ? cmg_pkg::YY_WRAP : yy - 7'd1);
   assign cen_adj = (early && yy_zero) ? cen_ff - 5'd1 : cen_ff;
   assign dsum    = {4'd0, cmg_pkg::month_term(month_ff)} + {4'd0, yy_adj[6:2]}
                    + {6'd0, cen_adj[4:2]} + 9'd1 + {2'd0, yy_adj} + cmg_pkg::DAY_BIAS
                    - {3'd0, cen_adj, 1'b0};
   assign leap    = (ylo_ff == 2'd0) && (!yy_zero || (cen_ff[1:0] == 2'd0));
   assign rem     = acc_ff[2:0];

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      cen_in   = cen_ff;
      month_in = month_ff;
      ylo_in   = ylo_ff;
      len_in   = len_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (bad_req) begin
                  cmd.go  = 1'b1;
                  cmd.err = 1'b1;
               end else begin
                  acc_in   = req_data.year;
                  cen_in   = 5'd0;
                  month_in = req_data.month;
                  ylo_in   = req_data.year[1:0];
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (ge) begin
               acc_in = diff;
               cen_in = cen_ff + 5'd1;
            end else begin
               acc_in = {3'd0, dsum};
               if (month_ff == cmg_pkg::MONTH_FEB) begin
                  len_in = leap ? cmg_pkg::LEN_29 : cmg_pkg::LEN_28;
               end else if ((month_ff == cmg_pkg::MONTH_APR) || (month_ff == cmg_pkg::MONTH_JUN)
                            || (month_ff == cmg_pkg::MONTH_SEP)
                            || (month_ff == cmg_pkg::MONTH_NOV)) begin
                  len_in = cmg_pkg::LEN_30;
               end else begin
                  len_in = cmg_pkg::LEN_31;
               end
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (ge) begin
               acc_in = diff;
            end else begin
               cmd.go   = 1'b1;
               cmd.err  = 1'b0;
               cmd.fw   = (rem == 3'd0) ? cmg_pkg::COL_SUN : rem - 3'd1;
               cmd.len  = len_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff   <= acc_in;
      cen_ff   <= cen_in;
      month_ff <= month_in;
      ylo_ff   <= ylo_in;
      len_ff   <= len_in;
   end

   cmg_grid u_grid (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .busy      (grid_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
